[rtl/stereo_iir_filter_macros.svh]
// assertion helpers for the stereo iir filter
// expects clk and rst to be in scope at the point of use
`ifndef STEREO_IIR_FILTER_MACROS_SVH
`define STEREO_IIR_FILTER_MACROS_SVH

// same-cycle implication
`define SIIR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("siir: same-cycle check failed");

// next-cycle implication
`define SIIR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("siir: next-cycle check failed");

`endif

[rtl/siir_pkg.sv]
// shared types and constants for the stereo iir filter
// no dependencies
`default_nettype none

package siir_pkg;

  localparam int TAP_COUNT = 2048;
  localparam int TAP_W     = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;

  localparam int SAMPLE_W = 16;
  localparam int COEFF_W  = 32;
  localparam int INDEX_W  = 11;
  localparam int OPCODE_W = 2;
  localparam int FRAC_W   = 30;

  localparam int PROD_W = COEFF_W + SAMPLE_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int ACC_W  = SUM_W + TAP_W + 1;

  typedef logic [OPCODE_W-1:0]        opcode_t;
  typedef logic [INDEX_W-1:0]         coeff_index_t;
  typedef logic signed [COEFF_W-1:0]  coeff_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [TAP_W-1:0]           tap_addr_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  localparam opcode_t OP_FRAME   = 2'd0;
  localparam opcode_t OP_LOAD_FF = 2'd1;
  localparam opcode_t OP_LOAD_FB = 2'd2;

  localparam tap_addr_t LAST_TAP = TAP_W'(TAP_COUNT - 1);

  typedef struct packed {
    logic      ff_we;
    logic      fb_we;
    tap_addr_t wr_addr;
    tap_addr_t rd_addr;
  } coeff_ctl_t;

  typedef struct packed {
    logic      x_we;
    logic      y_we;
    tap_addr_t wr_addr;
    logic      rd_en;
    tap_addr_t rd_addr;
    logic      acc_clr;
  } lane_ctl_t;

endpackage

`default_nettype wire

[rtl/siir_if.sv]
// valid/ready channel interfaces: command beats in, filtered frames out
// depends on siir_pkg
`default_nettype none

interface siir_cmd_if;
  import siir_pkg::*;

  logic         valid;
  logic         ready;
  opcode_t      opcode;
  coeff_index_t coeff_index;
  coeff_t       coeff_value;
  sample_t      left_sample;
  sample_t      right_sample;

  modport source (output valid, opcode, coeff_index, coeff_value, left_sample, right_sample,
                  input ready);
  modport sink (input valid, opcode, coeff_index, coeff_value, left_sample, right_sample,
                output ready);
endinterface

interface siir_result_if;
  import siir_pkg::*;

  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink (input valid, left_out, right_out, output ready);
endinterface

`default_nettype wire

[rtl/siir_coeff_store.sv]
// shared feed-forward and feedback coefficient memories
// one write and one registered read per cycle; depends on siir_pkg
`default_nettype none

module siir_coeff_store (
  input  logic                clk,
  input  siir_pkg::coeff_ctl_t ctl,
  input  siir_pkg::coeff_t    wdata,
  output siir_pkg::coeff_t    ff_q,
  output siir_pkg::coeff_t    fb_q
);
  import siir_pkg::*;

  coeff_t ff_mem [TAP_COUNT];
  coeff_t fb_mem [TAP_COUNT];

  always_ff @(posedge clk) begin
    if (ctl.ff_we) begin
      ff_mem[ctl.wr_addr] <= wdata;
    end
    if (ctl.fb_we) begin
      fb_mem[ctl.wr_addr] <= wdata;
    end
    ff_q <= ff_mem[ctl.rd_addr];
    fb_q <= fb_mem[ctl.rd_addr];
  end

endmodule

`default_nettype wire

[rtl/siir_lane.sv]
// one channel: input and output history rings plus a pipelined dual mac
// read -> multiply -> add products -> accumulate; depends on siir_pkg
`default_nettype none

module siir_lane (
  input  logic                clk,
  input  logic                rst,
  input  siir_pkg::lane_ctl_t ctl,
  input  siir_pkg::sample_t   x_wdata,
  input  siir_pkg::sample_t   y_wdata,
  input  siir_pkg::coeff_t    ff_coeff,
  input  siir_pkg::coeff_t    fb_coeff,
  output siir_pkg::acc_t      acc,
  output logic                busy
);
  import siir_pkg::*;

  sample_t x_ring [TAP_COUNT];
  sample_t y_ring [TAP_COUNT];

  sample_t x_q;
  sample_t y_q;
  prod_t   ff_prod;
  prod_t   fb_prod;
  sum_t    tap_sum;
  logic    v1;
  logic    v2;
  logic    v3;

  always_ff @(posedge clk) begin
    if (ctl.x_we) begin
      x_ring[ctl.wr_addr] <= x_wdata;
    end
    if (ctl.y_we) begin
      y_ring[ctl.wr_addr] <= y_wdata;
    end
    x_q <= x_ring[ctl.rd_addr];
    y_q <= y_ring[ctl.rd_addr];
  end

  // coefficient read data arrives aligned with x_q and y_q
  always_ff @(posedge clk) begin
    ff_prod <= PROD_W'(ff_coeff) * PROD_W'(x_q);
    fb_prod <= PROD_W'(fb_coeff) * PROD_W'(y_q);
    tap_sum <= SUM_W'(ff_prod) + SUM_W'(fb_prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      acc <= '0;
    end else begin
      v1 <= ctl.rd_en;
      v2 <= v1;
      v3 <= v2;
      if (ctl.acc_clr) begin
        acc <= '0;
      end else if (v3) begin
        acc <= acc + ACC_W'(tap_sum);
      end
    end
  end

  assign busy = v1 | v2 | v3;

endmodule

`default_nettype wire

[rtl/siir_merge.sv]
// rounds and saturates both lane sums and holds the stereo result register
// depends on siir_pkg and siir_result_if
`default_nettype none

module siir_merge (
  input  logic              clk,
  input  logic              rst,
  input  siir_pkg::acc_t    acc_left,
  input  siir_pkg::acc_t    acc_right,
  input  logic              load,
  output siir_pkg::sample_t sat_left,
  output siir_pkg::sample_t sat_right,
  output logic              slot_free,
  siir_result_if.source     result
);
  import siir_pkg::*;

  localparam int RND_W = ACC_W + 1;
  localparam logic signed [RND_W-1:0] HALF   = RND_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(1) <<< (FRAC_W + SAMPLE_W - 1);

  function automatic sample_t round_sat(input acc_t a);
    logic signed [RND_W-1:0] r;
    begin
      r = RND_W'(a) + HALF;
      if (r >= SAT_HI) begin
        round_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else if (r < -SAT_HI) begin
        round_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
        round_sat = r[FRAC_W+SAMPLE_W-1:FRAC_W];
      end
    end
  endfunction

  assign sat_left  = round_sat(acc_left);
  assign sat_right = round_sat(acc_right);
  assign slot_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.left_out  <= sat_left;
      result.right_out <= sat_right;
    end
  end

endmodule

`default_nettype wire

[rtl/stereo_iir_filter.sv]
// stereo direct-form-i iir filter (left and right lanes, shared coefficients)
// Channels: cmd (sink) takes one beat per command: opcode 0 is a stereo frame
//   (left_sample, right_sample), opcode 1 / 2 write one feed-forward / feedback
//   coefficient at coeff_index; opcode 3 and out-of-range loads do nothing.
//   result (source) gives one beat with left_out and right_out per frame.
// Reset: rst clears control at once, then a clearing pass over all TAP_COUNT
//   addresses zeroes the coefficient memories and all four history rings; cmd.ready
//   stays low during that pass.
// Throughput: a coefficient load leaves cmd ready for the next command. A frame
//   walks all TAP_COUNT taps, one tap per cycle per lane, bounded by the single
//   read port of each ring and coefficient memory and one mac pair per lane; the
//   lanes then drain, the result beat is loaded once the output register is free,
//   and the next command is taken in the cycle after that.
// Stall: the result beat sits in an output register; cmd is taken while it waits.
//   A later frame finishes its sum and then holds until that register is free.
// Depends on siir_pkg, siir_if, siir_coeff_store, siir_lane, siir_merge and
//   stereo_iir_filter_macros.svh
`default_nettype none
`include "stereo_iir_filter_macros.svh"

module stereo_iir_filter (
  input  logic          clk,
  input  logic          rst,
  siir_cmd_if.sink      cmd,
  siir_result_if.source result
);
  import siir_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RUN    = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state;
  tap_addr_t  clr_addr;
  tap_addr_t  ptr;
  tap_addr_t  tap;
  tap_addr_t  idx;
  tap_addr_t  ptr_prev;

  logic       clearing;
  logic       cmd_fire;
  logic       frame_fire;
  logic       index_ok;
  logic       finish_go;
  logic       slot_free;
  logic       busy_left;
  logic       busy_right;
  logic       lane_busy;

  coeff_ctl_t coeff_ctl;
  lane_ctl_t  lane_ctl;
  coeff_t     coeff_wdata;
  coeff_t     ff_q;
  coeff_t     fb_q;
  sample_t    x_left;
  sample_t    x_right;
  sample_t    sat_left;
  sample_t    sat_right;
  sample_t    y_left;
  sample_t    y_right;
  acc_t       acc_left;
  acc_t       acc_right;

  assign clearing   = (state == ST_CLEAR);
  assign cmd.ready  = (state == ST_IDLE);
  assign cmd_fire   = cmd.valid && cmd.ready;
  assign frame_fire = cmd_fire && (cmd.opcode == OP_FRAME);
  assign index_ok   = 32'(cmd.coeff_index) < TAP_COUNT;
  assign finish_go  = (state == ST_FINISH) && slot_free;
  assign lane_busy  = busy_left | busy_right;
  assign ptr_prev   = (ptr == '0) ? LAST_TAP : ptr - 1'b1;

  always_comb begin
    coeff_ctl.ff_we   = clearing || (cmd_fire && cmd.opcode == OP_LOAD_FF && index_ok);
    coeff_ctl.fb_we   = clearing || (cmd_fire && cmd.opcode == OP_LOAD_FB && index_ok);
    coeff_ctl.wr_addr = clearing ? clr_addr : TAP_W'(cmd.coeff_index);
    coeff_ctl.rd_addr = tap;
    coeff_wdata       = clearing ? '0 : cmd.coeff_value;

    lane_ctl.x_we    = clearing || frame_fire;
    lane_ctl.y_we    = clearing || finish_go;
    lane_ctl.rd_en   = (state == ST_RUN);
    lane_ctl.rd_addr = idx;
    lane_ctl.acc_clr = frame_fire;
    if (clearing) begin
      lane_ctl.wr_addr = clr_addr;
    end else if (state == ST_FINISH) begin
      lane_ctl.wr_addr = ptr_prev;
    end else begin
      lane_ctl.wr_addr = ptr;
    end

    x_left  = clearing ? '0 : cmd.left_sample;
    x_right = clearing ? '0 : cmd.right_sample;
    y_left  = clearing ? '0 : sat_left;
    y_right = clearing ? '0 : sat_right;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      ptr      <= '0;
      tap      <= '0;
      idx      <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_TAP) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (frame_fire) begin
            tap   <= '0;
            idx   <= ptr;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          tap <= tap + 1'b1;
          idx <= (idx == LAST_TAP) ? '0 : idx + 1'b1;
          if (tap == LAST_TAP) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!lane_busy) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // new output goes one slot below the pointer, which then counts down
          if (slot_free) begin
            ptr   <= ptr_prev;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  siir_coeff_store u_coeff (
    .clk   (clk),
    .ctl   (coeff_ctl),
    .wdata (coeff_wdata),
    .ff_q  (ff_q),
    .fb_q  (fb_q)
  );

  siir_lane u_lane_left (
    .clk      (clk),
    .rst      (rst),
    .ctl      (lane_ctl),
    .x_wdata  (x_left),
    .y_wdata  (y_left),
    .ff_coeff (ff_q),
    .fb_coeff (fb_q),
    .acc      (acc_left),
    .busy     (busy_left)
  );

  siir_lane u_lane_right (
    .clk      (clk),
    .rst      (rst),
    .ctl      (lane_ctl),
    .x_wdata  (x_right),
    .y_wdata  (y_right),
    .ff_coeff (ff_q),
    .fb_coeff (fb_q),
    .acc      (acc_right),
    .busy     (busy_right)
  );

  siir_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .acc_left  (acc_left),
    .acc_right (acc_right),
    .load      (finish_go),
    .sat_left  (sat_left),
    .sat_right (sat_right),
    .slot_free (slot_free),
    .result    (result)
  );

  `SIIR_ASSERT_NOW(a_lanes_quiet_when_idle, state == ST_IDLE, !lane_busy)
  `SIIR_ASSERT_NEXT(a_frame_starts_run, frame_fire, state == ST_RUN && tap == '0)
  `SIIR_ASSERT_NEXT(a_pointer_moves_on_finish, finish_go, ptr != $past(ptr))

endmodule

`default_nettype wire
